### rtl/rmst_pkg.sv
// ============================================================================
// rmst_pkg
// Shared widths, command codes and controller states for the range-maximum
// segment tree.
// ============================================================================
package rmst_pkg;

    localparam int LEAF_COUNT_DEF = 1024;
    localparam int VALUE_W        = 32;
    localparam int LEAF_W         = 10;
    localparam int RANGE_W        = 11;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_UP,
        ST_QRY,
        ST_QDRAIN,
        ST_QDONE
    } rmst_state_t;

endpackage

### rtl/range_max_segment_tree.sv
// ============================================================================
// range_max_segment_tree
// Point-update / range-maximum segment tree over LEAF_COUNT signed leaves,
// held in one synchronous memory with two read ports and one write port.
// ============================================================================
// Update: writes the leaf, then each ancestor up to the root, then returns to idle.
// Query: walks the range up the tree in ST_QRY, then passes through ST_QDRAIN and ST_QDONE,
//   holding in ST_QDONE until the result register is free, then returns to idle.
// One item at a time; the registered reads of the tree memory set the walk.
// Reset: a clearing pass zeroes all 2*LEAF_COUNT entries, one a cycle;
//   cmd_stall stays high until it ends.
module range_max_segment_tree
    import rmst_pkg::*;
#(
    parameter int LEAF_COUNT = LEAF_COUNT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic                      command,
    input  logic [LEAF_W-1:0]         leaf_index,
    input  logic signed [VALUE_W-1:0] new_value,
    input  logic [RANGE_W-1:0]        range_lo,
    input  logic [RANGE_W-1:0]        range_hi,

    output logic                      res_valid,
    input  logic                      res_stall,
    output logic signed [VALUE_W-1:0] range_max
);

    localparam int LW    = $clog2(LEAF_COUNT);
    localparam int NW    = LW + 1;
    localparam int PW    = LW + 2;
    localparam int CW    = (RANGE_W > PW) ? RANGE_W : PW;
    localparam int DEPTH = 2 * LEAF_COUNT;

    // tree storage
    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic                      wr_en;
    logic [NW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [NW-1:0]             rd_a_addr;
    logic [NW-1:0]             rd_b_addr;
    logic signed [VALUE_W-1:0] rd_a_reg;
    logic signed [VALUE_W-1:0] rd_b_reg;

    rmst_state_t               state_reg, state_next;
    logic [NW-1:0]             clr_reg, clr_next;
    logic [NW-1:0]             node_reg, node_next;
    logic signed [VALUE_W-1:0] cur_reg, cur_next;
    logic [PW-1:0]             l_reg, l_next;
    logic [PW-1:0]             r_reg, r_next;
    logic                      take_l_reg, take_l_next;
    logic                      take_r_reg, take_r_next;
    logic                      have_reg, have_next;
    logic                      res_valid_reg, res_valid_next;
    logic signed [VALUE_W-1:0] res_data_reg, res_data_next;

    logic                      cmd_accept;
    logic                      res_free;
    logic [LW-1:0]             leaf_wrap;
    logic [CW-1:0]             lo_ext, hi_ext, lo_clamp, hi_clamp;
    logic [NW-1:0]             parent;
    logic signed [VALUE_W-1:0] up_max;
    logic [PW-1:0]             r_dec, l_inc;
    logic                      walk_more;
    logic signed [VALUE_W-1:0] comb_a, comb_b;
    logic                      have_a;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign res_valid  = res_valid_reg;
    assign range_max  = res_data_reg;
    assign res_free   = !res_valid_reg || !res_stall;

    assign leaf_wrap = LW'(leaf_index);
    assign lo_ext    = CW'(range_lo);
    assign hi_ext    = CW'(range_hi);
    assign lo_clamp  = (lo_ext > CW'(LEAF_COUNT)) ? CW'(LEAF_COUNT) : lo_ext;
    assign hi_clamp  = (hi_ext > CW'(LEAF_COUNT)) ? CW'(LEAF_COUNT) : hi_ext;

    assign parent = node_reg >> 1;
    assign up_max = (rd_a_reg > cur_reg) ? rd_a_reg : cur_reg;

    assign r_dec     = r_reg - PW'(1);
    assign l_inc     = l_reg + PW'(l_reg[0]);
    assign walk_more = (l_reg < r_reg);

    // fold the reads issued last cycle into the running maximum
    always_comb
    begin
        comb_a = cur_reg;
        have_a = have_reg;
        if (take_l_reg)
        begin
            comb_a = (have_reg && cur_reg > rd_a_reg) ? cur_reg : rd_a_reg;
            have_a = 1'b1;
        end
        comb_b = comb_a;
        if (take_r_reg)
        begin
            comb_b = (have_a && comb_a > rd_b_reg) ? comb_a : rd_b_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == NW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                    state_next = (command == CMD_UPDATE) ? ST_UPD_LEAF : ST_QRY;
            end
            ST_UPD_LEAF: state_next = ST_UPD_UP;
            ST_UPD_UP:
            begin
                if (parent == NW'(1))
                    state_next = ST_IDLE;
            end
            ST_QRY:
            begin
                if (!walk_more)
                    state_next = ST_QDRAIN;
            end
            ST_QDRAIN: state_next = ST_QDONE;
            ST_QDONE:
            begin
                if (res_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_next       = clr_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        take_l_next    = 1'b0;
        take_r_next    = 1'b0;
        have_next      = have_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        wr_en          = 1'b0;
        wr_addr        = node_reg;
        wr_data        = cur_reg;
        rd_a_addr      = {node_reg[NW-1:1], ~node_reg[0]};
        rd_b_addr      = r_dec[NW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + NW'(1);
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    node_next = {1'b1, leaf_wrap};
                    cur_next  = (command == CMD_UPDATE) ? new_value : '0;
                    have_next = 1'b0;
                    l_next    = PW'(lo_clamp) + PW'(LEAF_COUNT);
                    r_next    = PW'(hi_clamp) + PW'(LEAF_COUNT);
                end
            end
            ST_UPD_LEAF:
            begin
                // write the leaf, fetch its sibling
                wr_en = 1'b1;
            end
            ST_UPD_UP:
            begin
                // parent takes the larger child, fetch the parent's sibling
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = up_max;
                cur_next  = up_max;
                node_next = parent;
                rd_a_addr = {parent[NW-1:1], ~parent[0]};
            end
            ST_QRY:
            begin
                cur_next  = comb_b;
                have_next = have_a || take_r_reg;
                rd_a_addr = l_reg[NW-1:0];
                if (walk_more)
                begin
                    take_l_next = l_reg[0];
                    take_r_next = r_reg[0];
                    l_next      = l_inc >> 1;
                    r_next      = r_reg >> 1;
                end
            end
            ST_QDRAIN:
            begin
                cur_next  = comb_b;
                have_next = have_a || take_r_reg;
            end
            ST_QDONE:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = have_reg ? cur_reg : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            take_l_reg    <= 1'b0;
            take_r_reg    <= 1'b0;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            take_l_reg    <= take_l_next;
            take_r_reg    <= take_r_next;
            have_reg      <= have_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        cur_reg      <= cur_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        res_data_reg <= res_data_next;
    end

endmodule
